@@ hw/rtl/ist_pkg.sv @@
`default_nettype none
package ist_pkg;

  localparam logic [19:0] W_K       = 20'd658840;   // 0.2*pi, Q20
  localparam logic [22:0] PI_Q20    = 23'd3294199;
  localparam logic [22:0] HPI_Q20   = 23'd1647099;
  localparam logic [22:0] TWOPI_Q20 = 23'd6588397;
  localparam logic [23:0] GAIN_Q24  = 24'd10188012;
  localparam logic [22:0] AMP_MAX   = 23'h7FFFFF;

  // 2^42 / two pi (Q20), rounded down; a 32-bit angle times this, shifted
  // right by 42, is the whole number of turns or one less.
  localparam logic [19:0] TWOPI_RECIP = 20'(64'h400_0000_0000 / 64'd6588397);

  localparam int CORDIC_STEPS = 20;
  localparam int MOD_STEPS    = 3;
  localparam int DIV_STEPS    = 20;

  localparam logic [1:0] STAGE_UNWIND = 2'd0;
  localparam logic [1:0] STAGE_HOLD   = 2'd1;
  localparam logic [1:0] STAGE_REWIND = 2'd2;
  localparam logic [1:0] STAGE_DONE   = 2'd3;

  localparam logic [1:0] DIR_CW   = 2'd0;
  localparam logic [1:0] DIR_CCW  = 2'd1;
  localparam logic [1:0] DIR_NONE = 2'd2;

  localparam logic [2:0] REG_SAMPLE_RATE  = 3'd0;
  localparam logic [2:0] REG_SPEED_MAX    = 3'd1;
  localparam logic [2:0] REG_RADIUS_MAX   = 3'd2;
  localparam logic [2:0] REG_CIRCLE_COUNT = 3'd3;
  localparam logic [2:0] REG_DIRECTION    = 3'd4;

  typedef struct packed {
    logic       start;
    logic       restart;
    logic       mod_step;
    logic       prep;
    logic       dload;
    logic       iter;
    logic       sload;
    logic       sdiv;
    logic       upd;
    logic       out_load;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic done_stage;
  } status_t;

  // Arctangent of 2^-i in Q20.
  function automatic logic [19:0] atan_q20(input logic [4:0] i);
    logic [19:0] v;
    case (i)
      5'd0:  v = 20'd823550;
      5'd1:  v = 20'd486170;
      5'd2:  v = 20'd256879;
      5'd3:  v = 20'd130396;
      5'd4:  v = 20'd65451;
      5'd5:  v = 20'd32757;
      5'd6:  v = 20'd16383;
      5'd7:  v = 20'd8192;
      5'd8:  v = 20'd4096;
      5'd9:  v = 20'd2048;
      5'd10: v = 20'd1024;
      5'd11: v = 20'd512;
      5'd12: v = 20'd256;
      5'd13: v = 20'd128;
      5'd14: v = 20'd64;
      5'd15: v = 20'd32;
      5'd16: v = 20'd16;
      5'd17: v = 20'd8;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ist_ctrl.sv @@
`default_nettype none
module ist_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic            restart,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output ist_pkg::cmd_t        cmd,
  input  wire ist_pkg::status_t status
);
  import ist_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MOD   = 8'b00000010,
    S_PREP  = 8'b00000100,
    S_DLOAD = 8'b00001000,
    S_ITER  = 8'b00010000,
    S_SDIV  = 8'b00100000,
    S_UPD   = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       emit;

  assign s_tready = (state == S_IDLE);
  assign emit     = (state == S_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.idx      = cnt;
    cmd.restart  = restart;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.start = 1'b1;
          cnt_next  = 5'd0;
          if (restart || status.done_stage) state_next = S_FIN;
          else state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == 5'(MOD_STEPS - 1)) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.dload  = 1'b1;
        cnt_next   = 5'd0;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) begin
          cnt_next   = 5'd0;
          state_next = S_SDIV;
        end
      end
      S_SDIV: begin
        // The first cycle here loads the step division instead of running a step.
        if (cnt == 5'd0) cmd.sload = 1'b1;
        else cmd.sdiv = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS)) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (emit) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= 5'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ist_dp.sv @@
`default_nettype none
module ist_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ist_pkg::cmd_t    cmd,
  output ist_pkg::status_t      status,
  input  wire logic [9:0]       sample_rate,
  input  wire logic [9:0]       speed_max,
  input  wire logic [6:0]       radius_max,
  input  wire logic [7:0]       circle_count,
  input  wire logic [1:0]       direction,
  output logic [55:0]           m_tdata
);
  import ist_pkg::*;

  // Run state.
  logic [1:0]  stage;
  logic [31:0] angle;
  logic [22:0] amp;
  logic [31:0] end_angle;

  // Working registers.
  logic [31:0]        r_mod;
  logic [9:0]         mq;
  logic signed [24:0] z;
  logic               neg;
  logic signed [33:0] x, y;
  logic [32:0]        pa;
  logic [42:0]        pw;
  logic [45:0]        rem;
  logic [51:0]        ds;
  logic [19:0]        q;
  logic [19:0]        inc;
  logic signed [23:0] res_x, res_y;
  logic [1:0]         res_stage;
  logic               res_ent;

  logic [9:0]         rate;
  logic [45:0]        spd;
  logic [51:0]        rprod;
  logic [32:0]        mprod;
  logic signed [24:0] z0, z1;
  logic               neg0;
  logic [46:0]        gain_prod;
  logic signed [33:0] x_sh, y_sh;
  logic [19:0]        at;
  logic               ge;
  logic [32:0]        ang_sum, end_sum;
  logic [30:0]        turns;
  logic [31:0]        angle_n;
  logic [17:0]        step;
  logic [23:0]        amp_sum;
  logic signed [23:0] c_q, s_q;

  assign status.done_stage = (stage == STAGE_DONE);
  assign rate = (sample_rate == 10'd0) ? 10'd1 : sample_rate;
  assign spd  = {speed_max, 36'd0};
  assign rprod = r_mod * TWOPI_RECIP;
  assign mprod = mq * TWOPI_Q20;
  assign gain_prod = amp * GAIN_Q24;
  assign x_sh = x >>> cmd.idx;
  assign y_sh = y >>> cmd.idx;
  assign at   = atan_q20(cmd.idx);
  assign ge   = ({6'd0, rem} >= ds);
  assign step = q[17:0];

  function automatic logic signed [23:0] round_out(input logic signed [33:0] v,
                                                   input logic n);
    logic signed [34:0] r;
    r = 35'(v + 34'sd128) >>> 8;
    if (n) r = -r;
    if (r > 35'sd8388607) return 24'sh7FFFFF;
    if (r < -35'sd8388608) return 24'sh800000;
    return r[23:0];
  endfunction

  always_comb begin
    z0   = $signed({2'b00, r_mod[22:0]});
    neg0 = 1'b0;
    if (z0 > $signed({2'b00, PI_Q20})) z0 = z0 - $signed({2'b00, TWOPI_Q20});
    z1 = z0;
    if (z0 > $signed({2'b00, HPI_Q20})) begin
      z1   = z0 - $signed({2'b00, PI_Q20});
      neg0 = 1'b1;
    end else if (z0 < -$signed({2'b00, HPI_Q20})) begin
      z1   = z0 + $signed({2'b00, PI_Q20});
      neg0 = 1'b1;
    end
  end

  always_comb begin
    ang_sum = {1'b0, angle} + {13'd0, inc};
    angle_n = ang_sum[32] ? 32'hFFFFFFFF : ang_sum[31:0];
    turns   = TWOPI_Q20 * circle_count;
    end_sum = {1'b0, angle_n} + {2'b00, turns};
    amp_sum = {1'b0, amp} + {6'd0, step};
    c_q     = round_out(x, neg);
    s_q     = round_out(y, neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= STAGE_UNWIND;
      angle     <= '0;
      amp       <= '0;
      end_angle <= '0;
    end else begin
      if (cmd.start && cmd.restart) begin
        stage     <= STAGE_UNWIND;
        angle     <= '0;
        amp       <= '0;
        end_angle <= '0;
      end
      if (cmd.upd) begin
        angle <= angle_n;
        case (stage)
          STAGE_UNWIND: begin
            if (amp < {radius_max, 16'd0}) begin
              amp <= amp_sum[23] ? AMP_MAX : amp_sum[22:0];
            end else begin
              stage     <= STAGE_HOLD;
              end_angle <= end_sum[32] ? 32'hFFFFFFFF : end_sum[31:0];
            end
          end
          STAGE_HOLD: begin
            if (angle_n >= end_angle) stage <= STAGE_REWIND;
          end
          default: begin
            if (amp != 23'd0) amp <= (amp > {5'd0, step}) ? amp - {5'd0, step} : 23'd0;
            else stage <= STAGE_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_mod     <= angle;
      res_x     <= '0;
      res_y     <= '0;
      res_ent   <= 1'b0;
      res_stage <= cmd.restart ? STAGE_UNWIND : stage;
    end
    // Angle reduction: estimate the turns by a reciprocal multiply, take
    // them off, then one compare and subtract covers the low estimate.
    if (cmd.mod_step) begin
      case (cmd.idx)
        5'd0: mq <= rprod[51:42];
        5'd1: r_mod <= r_mod - mprod[31:0];
        default: begin
          if (r_mod >= {9'd0, TWOPI_Q20}) r_mod <= r_mod - {9'd0, TWOPI_Q20};
        end
      endcase
    end
    if (cmd.prep) begin
      z   <= z1;
      neg <= neg0;
      x   <= $signed({3'b000, gain_prod[46:16]});
      y   <= '0;
      pa  <= rate * amp;
      pw  <= amp * W_K;
    end
    if (cmd.dload) begin
      q <= '0;
      if ({3'd0, pw} > spd) begin
        rem <= spd;
        ds  <= {pa, 19'd0};
      end else begin
        rem <= {26'd0, W_K} + {37'd0, rate[9:1]};
        ds  <= {23'd0, rate, 19'd0};
      end
    end
    if (cmd.iter) begin
      if (z >= 0) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - $signed({5'd0, at});
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + $signed({5'd0, at});
      end
    end
    if (cmd.iter || cmd.sdiv) begin
      if (ge) rem <= rem - ds[45:0];
      q  <= {q[18:0], ge};
      ds <= ds >> 1;
    end
    if (cmd.sload) begin
      inc <= q;
      q   <= '0;
      rem <= 46'd131072;
      ds  <= {23'd0, rate, 19'd0};
    end
    if (cmd.upd) begin
      case (direction)
        DIR_CW: begin
          res_x <= s_q;
          res_y <= c_q;
        end
        DIR_CCW: begin
          res_x <= c_q;
          res_y <= s_q;
        end
        default: begin
          res_x <= '0;
          res_y <= '0;
        end
      endcase
      res_ent   <= 1'b0;
      res_stage <= stage;
      case (stage)
        STAGE_UNWIND: begin
          if (amp >= {radius_max, 16'd0}) begin
            res_stage <= STAGE_HOLD;
            res_ent   <= 1'b1;
          end
        end
        STAGE_HOLD: begin
          if (angle_n >= end_angle) begin
            res_stage <= STAGE_REWIND;
            res_ent   <= 1'b1;
          end
        end
        default: begin
          if (amp == 23'd0) begin
            res_stage <= STAGE_DONE;
            res_ent   <= 1'b1;
          end
        end
      endcase
    end
    if (cmd.out_load) begin
      m_tdata <= {4'd0, (res_stage == STAGE_DONE), res_ent, res_stage, res_y, res_x};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/involute_spiral_target_generator.sv @@
`default_nettype none
// Involute spiral target generator. Each input item is a sample tick
// (s_tdata[0] low) or a restart (s_tdata[0] high); each gives exactly one
// result item holding the Q8.16 target point, the stage, a stage-entered
// flag and a finished flag. A tick goes from acceptance to the result
// through angle reduction modulo two pi (a reciprocal multiply, a
// subtract and one correction), a setup, a divider load, 20 shared CORDIC
// and divider steps, the amplitude-step division, an update and an output.
// Restarts and ticks after the run has finished go straight to the output.
// One item is in work at a time; the output register lets the next item
// be accepted while a result still waits. The user must write registers
// over the APB port only while idle; the block does not enforce this.
module involute_spiral_target_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [23:0] target_x, [47:24] target_y,
                                      // [49:48] stage, [50] stage_entered,
                                      // [51] finished
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ist_pkg::*;

  logic [9:0] sample_rate;
  logic [9:0] speed_max;
  logic [6:0] radius_max;
  logic [7:0] circle_count;
  logic [1:0] direction;
  cmd_t       cmd;
  status_t    status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= 10'd50;
      speed_max    <= 10'd20;
      radius_max   <= 7'd50;
      circle_count <= 8'd3;
      direction    <= DIR_CW;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_SAMPLE_RATE:  sample_rate  <= pwdata[9:0];
        REG_SPEED_MAX:    speed_max    <= pwdata[9:0];
        REG_RADIUS_MAX:   radius_max   <= pwdata[6:0];
        REG_CIRCLE_COUNT: circle_count <= pwdata[7:0];
        REG_DIRECTION:    direction    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SAMPLE_RATE:  prdata = {22'd0, sample_rate};
      REG_SPEED_MAX:    prdata = {22'd0, speed_max};
      REG_RADIUS_MAX:   prdata = {25'd0, radius_max};
      REG_CIRCLE_COUNT: prdata = {24'd0, circle_count};
      REG_DIRECTION:    prdata = {30'd0, direction};
      default:          prdata = 32'd0;
    endcase
  end

  ist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .restart  (s_tdata[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  ist_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_rate  (sample_rate),
    .speed_max    (speed_max),
    .radius_max   (radius_max),
    .circle_count (circle_count),
    .direction    (direction),
    .m_tdata      (m_tdata)
  );

endmodule
`default_nettype wire
